// File: rtl/core/psde_pkg.sv
// Package with shared types, constants and byte tables of the PNG stored-deflate encoder.
package psde_pkg;

    localparam int MAX_DIMENSION = 8192;
    localparam int DIM_W = 14;
    localparam int IDX_W = 6;

    localparam logic [IDX_W-1:0] HDR_LAST = 6'd42;
    localparam logic [IDX_W-1:0] TRL_LAST = 6'd19;
    localparam logic [IDX_W-1:0] BLK_LAST = 6'd4;
    localparam logic [2:0] SLOT_LAST = 3'd4;

    localparam logic [1:0] CFG_WIDTH = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pixel;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_run;
        logic       end_of_file;
    } t_result;

    typedef enum logic [3:0] {
        SRC_CONST,
        SRC_WIDTH,
        SRC_HEIGHT,
        SRC_CRC,
        SRC_LEN,
        SRC_ADLER,
        SRC_BLK,
        SRC_PIXEL
    } t_src;

    typedef enum logic [1:0] {
        CRC_HOLD,
        CRC_UPDATE,
        CRC_RESTART
    } t_crc_mode;

    typedef struct packed {
        t_src       src;
        logic [2:0] lane;
        logic [7:0] value;
        t_crc_mode  crc;
    } t_entry;

    typedef struct packed {
        logic       emit;
        t_entry     ent;
        logic       eor;
        logic       eof;
        logic       take;
        logic       start_file;
        logic       load_stream;
        logic       raw;
        logic       pixel_done;
        logic       set_pending;
        logic       end_file;
    } t_cmd;

    typedef struct packed {
        logic ld_ok;
        logic header_done;
        logic pending;
        logic fill_zero;
        logic last_pixel;
        logic col_zero;
    } t_status;

    // Signature, IHDR chunk and the opening of the IDAT chunk.
    function automatic t_entry hdr_entry(input logic [IDX_W-1:0] idx);
        t_entry e;
        e = '{src: SRC_CONST, lane: 3'd0, value: 8'd0, crc: CRC_UPDATE};
        unique case (idx)
            6'd0:  e = '{SRC_CONST, 3'd0, 8'd137, CRC_HOLD};
            6'd1:  e = '{SRC_CONST, 3'd0, 8'd80, CRC_HOLD};
            6'd2:  e = '{SRC_CONST, 3'd0, 8'd78, CRC_HOLD};
            6'd3:  e = '{SRC_CONST, 3'd0, 8'd71, CRC_HOLD};
            6'd4:  e = '{SRC_CONST, 3'd0, 8'd13, CRC_HOLD};
            6'd5:  e = '{SRC_CONST, 3'd0, 8'd10, CRC_HOLD};
            6'd6:  e = '{SRC_CONST, 3'd0, 8'd26, CRC_HOLD};
            6'd7:  e = '{SRC_CONST, 3'd0, 8'd10, CRC_HOLD};
            6'd8:  e = '{SRC_CONST, 3'd0, 8'd0, CRC_HOLD};
            6'd9:  e = '{SRC_CONST, 3'd0, 8'd0, CRC_HOLD};
            6'd10: e = '{SRC_CONST, 3'd0, 8'd0, CRC_HOLD};
            6'd11: e = '{SRC_CONST, 3'd0, 8'd13, CRC_HOLD};
            6'd12: e = '{SRC_CONST, 3'd0, 8'd73, CRC_RESTART};
            6'd13: e = '{SRC_CONST, 3'd0, 8'd72, CRC_UPDATE};
            6'd14: e = '{SRC_CONST, 3'd0, 8'd68, CRC_UPDATE};
            6'd15: e = '{SRC_CONST, 3'd0, 8'd82, CRC_UPDATE};
            6'd18: e = '{SRC_WIDTH, 3'd1, 8'd0, CRC_UPDATE};
            6'd19: e = '{SRC_WIDTH, 3'd0, 8'd0, CRC_UPDATE};
            6'd22: e = '{SRC_HEIGHT, 3'd1, 8'd0, CRC_UPDATE};
            6'd23: e = '{SRC_HEIGHT, 3'd0, 8'd0, CRC_UPDATE};
            6'd24: e = '{SRC_CONST, 3'd0, 8'd8, CRC_UPDATE};
            6'd25: e = '{SRC_CONST, 3'd0, 8'd6, CRC_UPDATE};
            6'd29: e = '{SRC_CRC, 3'd3, 8'd0, CRC_HOLD};
            6'd30: e = '{SRC_CRC, 3'd2, 8'd0, CRC_HOLD};
            6'd31: e = '{SRC_CRC, 3'd1, 8'd0, CRC_HOLD};
            6'd32: e = '{SRC_CRC, 3'd0, 8'd0, CRC_HOLD};
            6'd33: e = '{SRC_LEN, 3'd3, 8'd0, CRC_HOLD};
            6'd34: e = '{SRC_LEN, 3'd2, 8'd0, CRC_HOLD};
            6'd35: e = '{SRC_LEN, 3'd1, 8'd0, CRC_HOLD};
            6'd36: e = '{SRC_LEN, 3'd0, 8'd0, CRC_HOLD};
            6'd37: e = '{SRC_CONST, 3'd0, 8'd73, CRC_RESTART};
            6'd38: e = '{SRC_CONST, 3'd0, 8'd68, CRC_UPDATE};
            6'd39: e = '{SRC_CONST, 3'd0, 8'd65, CRC_UPDATE};
            6'd40: e = '{SRC_CONST, 3'd0, 8'd84, CRC_UPDATE};
            6'd41: e = '{SRC_CONST, 3'd0, 8'h78, CRC_UPDATE};
            6'd42: e = '{SRC_CONST, 3'd0, 8'h01, CRC_UPDATE};
            default: e = '{SRC_CONST, 3'd0, 8'd0, CRC_UPDATE};
        endcase
        return e;
    endfunction

    // Adler-32, IDAT CRC and the whole IEND chunk with its fixed CRC.
    function automatic t_entry trl_entry(input logic [IDX_W-1:0] idx);
        t_entry e;
        e = '{src: SRC_CONST, lane: 3'd0, value: 8'd0, crc: CRC_HOLD};
        unique case (idx)
            6'd0:  e = '{SRC_ADLER, 3'd3, 8'd0, CRC_UPDATE};
            6'd1:  e = '{SRC_ADLER, 3'd2, 8'd0, CRC_UPDATE};
            6'd2:  e = '{SRC_ADLER, 3'd1, 8'd0, CRC_UPDATE};
            6'd3:  e = '{SRC_ADLER, 3'd0, 8'd0, CRC_UPDATE};
            6'd4:  e = '{SRC_CRC, 3'd3, 8'd0, CRC_HOLD};
            6'd5:  e = '{SRC_CRC, 3'd2, 8'd0, CRC_HOLD};
            6'd6:  e = '{SRC_CRC, 3'd1, 8'd0, CRC_HOLD};
            6'd7:  e = '{SRC_CRC, 3'd0, 8'd0, CRC_HOLD};
            6'd12: e = '{SRC_CONST, 3'd0, 8'd73, CRC_HOLD};
            6'd13: e = '{SRC_CONST, 3'd0, 8'd69, CRC_HOLD};
            6'd14: e = '{SRC_CONST, 3'd0, 8'd78, CRC_HOLD};
            6'd15: e = '{SRC_CONST, 3'd0, 8'd68, CRC_HOLD};
            6'd16: e = '{SRC_CONST, 3'd0, 8'hAE, CRC_HOLD};
            6'd17: e = '{SRC_CONST, 3'd0, 8'h42, CRC_HOLD};
            6'd18: e = '{SRC_CONST, 3'd0, 8'h60, CRC_HOLD};
            6'd19: e = '{SRC_CONST, 3'd0, 8'h82, CRC_HOLD};
            default: e = '{SRC_CONST, 3'd0, 8'd0, CRC_HOLD};
        endcase
        return e;
    endfunction

endpackage

// File: rtl/core/psde_ctrl.sv
// Sequencer that decides which byte of the PNG stream goes out next.
module psde_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  psde_pkg::t_status i_status,
    output psde_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR,
        S_RAW,
        S_BLK,
        S_TRL
    } t_state;

    t_state                       r_state, n_state;
    logic [psde_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic [2:0]                   r_slot, n_slot;
    logic                         r_blk_sent, n_blk_sent;
    logic                         r_hdr_call, n_hdr_call;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_slot     = r_slot;
        n_blk_sent = r_blk_sent;
        n_hdr_call = r_hdr_call;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_idx      = '0;
                    n_blk_sent = 1'b0;
                    n_hdr_call = 1'b0;
                    if (i_status.pending) begin
                        n_state = S_TRL;
                    end else if (!i_status.header_done) begin
                        o_cmd.start_file = 1'b1;
                        n_hdr_call       = 1'b1;
                        n_state          = S_HDR;
                    end else begin
                        n_slot  = i_status.col_zero ? 3'd0 : 3'd1;
                        n_state = S_RAW;
                    end
                end
            end
            S_HDR: begin
                if (i_status.ld_ok) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.ent  = psde_pkg::hdr_entry(r_idx);
                    if (r_idx == psde_pkg::HDR_LAST) begin
                        o_cmd.load_stream = 1'b1;
                        n_slot            = 3'd0;
                        n_state           = S_RAW;
                    end else begin
                        n_idx = r_idx + 6'd1;
                    end
                end
            end
            S_RAW: begin
                if (i_status.fill_zero && !r_blk_sent) begin
                    // A new stored block starts here: send its five header bytes first.
                    n_idx   = '0;
                    n_state = S_BLK;
                end else if (i_status.ld_ok) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.raw  = 1'b1;
                    o_cmd.ent.crc = psde_pkg::CRC_UPDATE;
                    if (r_slot == 3'd0) begin
                        o_cmd.ent.src = psde_pkg::SRC_CONST;
                    end else begin
                        o_cmd.ent.src  = psde_pkg::SRC_PIXEL;
                        o_cmd.ent.lane = 3'd4 - r_slot;
                    end
                    n_blk_sent = 1'b0;
                    if (r_slot == psde_pkg::SLOT_LAST) begin
                        o_cmd.pixel_done = 1'b1;
                        o_cmd.eor = !i_status.last_pixel || r_hdr_call;
                        if (i_status.last_pixel && !r_hdr_call) begin
                            n_idx   = '0;
                            n_state = S_TRL;
                        end else begin
                            o_cmd.set_pending = i_status.last_pixel;
                            n_state           = S_IDLE;
                        end
                    end else begin
                        n_slot = r_slot + 3'd1;
                    end
                end
            end
            S_BLK: begin
                if (i_status.ld_ok) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.ent.src  = psde_pkg::SRC_BLK;
                    o_cmd.ent.lane = r_idx[2:0];
                    o_cmd.ent.crc  = psde_pkg::CRC_UPDATE;
                    if (r_idx == psde_pkg::BLK_LAST) begin
                        n_blk_sent = 1'b1;
                        n_state    = S_RAW;
                    end else begin
                        n_idx = r_idx + 6'd1;
                    end
                end
            end
            S_TRL: begin
                if (i_status.ld_ok) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.ent  = psde_pkg::trl_entry(r_idx);
                    if (r_idx == psde_pkg::TRL_LAST) begin
                        o_cmd.eor      = 1'b1;
                        o_cmd.eof      = 1'b1;
                        o_cmd.end_file = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        n_idx = r_idx + 6'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_slot     <= '0;
            r_blk_sent <= 1'b0;
            r_hdr_call <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_slot     <= n_slot;
            r_blk_sent <= n_blk_sent;
            r_hdr_call <= n_hdr_call;
        end
    end

endmodule

// File: rtl/core/psde_datapath.sv
// Datapath: configuration, frame counters, CRC-32, Adler-32, length math and output register.
module psde_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [1:0]                    i_cfg_index,
    input  logic [psde_pkg::DIM_W-1:0]    i_cfg_data,
    input  psde_pkg::t_pixel              i_in_pixel,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output psde_pkg::t_result             o_out_result,
    input  psde_pkg::t_cmd                i_cmd,
    output psde_pkg::t_status             o_status
);

    localparam logic [psde_pkg::DIM_W-1:0] DIM_MAX = psde_pkg::DIM_W'(psde_pkg::MAX_DIMENSION);

    logic [psde_pkg::DIM_W-1:0] r_cfg_w, r_cfg_h;
    logic [psde_pkg::DIM_W-1:0] r_fw, r_fh;
    logic [12:0]                r_col, r_row;
    logic [15:0]                r_fill;
    logic [28:0]                r_rem;
    logic [31:0]                r_crc;
    logic [15:0]                r_adl_lo, r_adl_hi;
    logic                       r_hdr_done, r_pending;
    psde_pkg::t_pixel           r_pix;
    logic [28:0]                r_raw;
    logic [13:0]                r_blocks;
    logic [31:0]                r_len;
    logic                       r_out_valid;
    psde_pkg::t_result          r_out;

    logic [28:0] w_prod;
    logic [12:0] w_hi;
    logic [16:0] w_sum, w_rem17;
    logic        w_ge;
    logic [13:0] w_blocks;
    logic [7:0]  w_byte;
    logic [15:0] w_blen;
    logic        w_last_col, w_last_row;
    logic [16:0] w_lo_sum, w_hi_sum;
    logic [15:0] w_lo_next, w_hi_next;

    function automatic logic [psde_pkg::DIM_W-1:0] clamp_dim(
        input logic [psde_pkg::DIM_W-1:0] v
    );
        logic [psde_pkg::DIM_W-1:0] c;
        c = v;
        if (v == '0) begin
            c = psde_pkg::DIM_W'(1);
        end else if (v > DIM_MAX) begin
            c = DIM_MAX;
        end
        return c;
    endfunction

    function automatic logic [7:0] pick(input logic [31:0] w, input logic [1:0] lane);
        logic [7:0] b;
        case (lane)
            2'd3:    b = w[31:24];
            2'd2:    b = w[23:16];
            2'd1:    b = w[15:8];
            default: b = w[7:0];
        endcase
        return b;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? (32'hEDB88320 ^ (x >> 1)) : (x >> 1);
        end
        return x;
    endfunction

    // Raw byte count and number of stored blocks (division by 65535 via 2^16 - 1).
    assign w_prod   = 29'(r_fh) * 29'({r_fw, 2'b00} + 16'd1);
    assign w_hi     = r_raw[28:16];
    assign w_sum    = 17'(w_hi) + 17'(r_raw[15:0]);
    assign w_ge     = (w_sum >= 17'd65535);
    assign w_rem17  = w_ge ? (w_sum - 17'd65535) : w_sum;
    assign w_blocks = 14'(w_hi) + 14'(w_ge) + 14'(w_rem17 != 17'd0);

    assign w_blen = (r_rem > 29'd65535) ? 16'hFFFF : r_rem[15:0];

    always_comb begin
        case (i_cmd.ent.src)
            psde_pkg::SRC_CONST:  w_byte = i_cmd.ent.value;
            psde_pkg::SRC_WIDTH:  w_byte = pick(32'(r_fw), i_cmd.ent.lane[1:0]);
            psde_pkg::SRC_HEIGHT: w_byte = pick(32'(r_fh), i_cmd.ent.lane[1:0]);
            psde_pkg::SRC_CRC:    w_byte = pick(~r_crc, i_cmd.ent.lane[1:0]);
            psde_pkg::SRC_LEN:    w_byte = pick(r_len, i_cmd.ent.lane[1:0]);
            psde_pkg::SRC_ADLER:  w_byte = pick({r_adl_hi, r_adl_lo}, i_cmd.ent.lane[1:0]);
            psde_pkg::SRC_PIXEL:  w_byte = pick(r_pix, i_cmd.ent.lane[1:0]);
            psde_pkg::SRC_BLK: begin
                case (i_cmd.ent.lane)
                    3'd0:    w_byte = {7'd0, (r_rem <= 29'd65535)};
                    3'd1:    w_byte = w_blen[7:0];
                    3'd2:    w_byte = w_blen[15:8];
                    3'd3:    w_byte = ~w_blen[7:0];
                    default: w_byte = ~w_blen[15:8];
                endcase
            end
            default: w_byte = 8'd0;
        endcase
    end

    assign w_lo_sum  = 17'(r_adl_lo) + 17'(w_byte);
    assign w_lo_next = (w_lo_sum >= 17'd65521) ? 16'(w_lo_sum - 17'd65521) : w_lo_sum[15:0];
    assign w_hi_sum  = 17'(r_adl_hi) + 17'(w_lo_next);
    assign w_hi_next = (w_hi_sum >= 17'd65521) ? 16'(w_hi_sum - 17'd65521) : w_hi_sum[15:0];

    assign w_last_col = ({1'b0, r_col} == r_fw - 14'd1);
    assign w_last_row = ({1'b0, r_row} == r_fh - 14'd1);

    assign o_status.ld_ok       = !r_out_valid || !i_out_stall;
    assign o_status.header_done = r_hdr_done;
    assign o_status.pending     = r_pending;
    assign o_status.fill_zero   = (r_fill == 16'd0);
    assign o_status.last_pixel  = w_last_col && w_last_row;
    assign o_status.col_zero    = (r_col == 13'd0);

    assign o_out_valid  = r_out_valid;
    assign o_out_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= psde_pkg::DIM_W'(1);
            r_cfg_h     <= psde_pkg::DIM_W'(1);
            r_fw        <= psde_pkg::DIM_W'(1);
            r_fh        <= psde_pkg::DIM_W'(1);
            r_col       <= '0;
            r_row       <= '0;
            r_fill      <= '0;
            r_rem       <= '0;
            r_crc       <= '1;
            r_adl_lo    <= 16'd1;
            r_adl_hi    <= '0;
            r_hdr_done  <= 1'b0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_index == psde_pkg::CFG_WIDTH) begin
                r_cfg_w <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == psde_pkg::CFG_HEIGHT) begin
                r_cfg_h <= i_cfg_data;
            end
            if (i_cmd.start_file) begin
                r_fw       <= clamp_dim(r_cfg_w);
                r_fh       <= clamp_dim(r_cfg_h);
                r_hdr_done <= 1'b1;
            end
            if (i_cmd.load_stream) begin
                r_rem    <= r_raw;
                r_fill   <= '0;
                r_adl_lo <= 16'd1;
                r_adl_hi <= '0;
                r_col    <= '0;
                r_row    <= '0;
            end
            if (i_cmd.raw) begin
                r_adl_lo <= w_lo_next;
                r_adl_hi <= w_hi_next;
                r_rem    <= r_rem - 29'd1;
                r_fill   <= (r_fill == 16'd65534) ? 16'd0 : r_fill + 16'd1;
            end
            if (i_cmd.pixel_done) begin
                if (w_last_col) begin
                    r_col <= '0;
                    r_row <= r_row + 13'd1;
                end else begin
                    r_col <= r_col + 13'd1;
                end
            end
            if (i_cmd.set_pending) begin
                r_pending <= 1'b1;
            end
            if (i_cmd.end_file) begin
                r_hdr_done <= 1'b0;
                r_pending  <= 1'b0;
            end
            if (i_cmd.emit) begin
                case (i_cmd.ent.crc)
                    psde_pkg::CRC_UPDATE:  r_crc <= crc_byte(r_crc, w_byte);
                    psde_pkg::CRC_RESTART: r_crc <= crc_byte(32'hFFFFFFFF, w_byte);
                    default:               r_crc <= r_crc;
                endcase
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers; the length pipeline settles long before the length bytes go out.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pix <= i_in_pixel;
        end
        if (i_cmd.emit) begin
            r_out.out_byte    <= w_byte;
            r_out.end_of_run  <= i_cmd.eor;
            r_out.end_of_file <= i_cmd.eof;
        end
        r_raw    <= w_prod;
        r_blocks <= w_blocks;
        r_len    <= 32'(r_raw) + 32'({r_blocks, 2'b00}) + 32'(r_blocks) + 32'd6;
    end

endmodule

// File: rtl/core/png_stored_deflate_encoder.sv
// Top level of the PNG encoder for RGBA8 pixels using stored (uncompressed) deflate blocks.
//
//   Channel   Direction  Handshake               Payload
//   in        into       i_in_valid / o_in_stall  i_in_pixel   (red, green, blue, alpha)
//   out       out of     o_out_valid / i_out_stall o_out_result (out_byte, end_of_run, end_of_file)
//   cfg       into       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Each pixel request is taken while the sequencer is idle; it then sends one byte per cycle
// through the output register while that register can load: 4 bytes for an ordinary pixel,
// one more at a row start, 5 more at a stored block boundary, 43 more for the file header on
// the first pixel and 20 for the trailer after the last. No byte goes out while the pixel is
// taken or a block is opened. Otherwise only a stalled output register holds the sequencer
// back: while it is stalled and full, the sequencer waits, and a new pixel is taken only once
// the sequencer is back in idle. Reset is synchronous and active low, and it returns the
// frame size registers to 1 by 1. No clearing pass is needed after reset.
module png_stored_deflate_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  psde_pkg::t_pixel              i_in_pixel,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output psde_pkg::t_result             o_out_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [psde_pkg::DIM_W-1:0]    i_cfg_data
);

    psde_pkg::t_cmd    w_cmd;
    psde_pkg::t_status w_status;

    // Configuration writes are always taken; they only matter for the next file.
    assign o_cfg_ready = 1'b1;

    // The controller walks the header, block, raw and trailer byte sequences.
    psde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the image state, both checksums and the output register.
    psde_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_pixel   (i_in_pixel),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_result (o_out_result),
        .i_cmd        (w_cmd),
        .o_status     (w_status)
    );

endmodule

// File: tb/sv/tb_png_stored_deflate_encoder.sv
// Testbench of the PNG stored-deflate encoder: a reference predictor and byte-by-byte checks.
module tb_png_stored_deflate_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_MAX = 53;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 30000000;

    // One request for the driver: either a pixel or a register write.
    typedef struct {
        bit               is_cfg;
        logic [1:0]       idx;
        logic [13:0]      data;
        psde_pkg::t_pixel px;
    } t_request;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    psde_pkg::t_pixel  i_in_pixel;
    logic              o_out_valid;
    logic              i_out_stall;
    psde_pkg::t_result o_out_result;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [13:0]       i_cfg_data;

    png_stored_deflate_encoder i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_pixel   (i_in_pixel),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_result (o_out_result),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    t_request          pending[$];
    psde_pkg::t_result expected_bytes[$];
    int                errors = 0;
    int                cycles = 0;

    // Predictor state: register copies, latched frame size and stream state.
    logic [31:0]       reg_width, reg_height;
    logic [31:0]       frame_w, frame_h;
    logic [31:0]       col_count, row_count, block_fill, raw_left;
    logic [31:0]       idat_crc, adler_lo, adler_hi;
    bit                header_sent, trailer_owed;
    psde_pkg::t_result run_bytes[$];

    function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            r = r[0] ? (32'hEDB88320 ^ (r >> 1)) : (r >> 1);
        return r;
    endfunction

    function automatic logic [31:0] clamp_size(input logic [31:0] v);
        if (v == 0) return 1;
        if (v > psde_pkg::MAX_DIMENSION) return psde_pkg::MAX_DIMENSION;
        return v;
    endfunction

    // The block never emits more than RUN_MAX bytes for one pixel.
    task automatic put_byte(input logic [7:0] b);
        psde_pkg::t_result r;
        r.out_byte = b;
        r.end_of_run = 1'b0;
        r.end_of_file = 1'b0;
        if (run_bytes.size() < RUN_MAX)
            run_bytes.insert(run_bytes.size(), r);
    endtask

    task automatic put_crc_byte(input logic [7:0] b);
        idat_crc = crc_update(idat_crc, b);
        put_byte(b);
    endtask

    task automatic put_word(input logic [31:0] x, input bit with_crc);
        for (int s = 3; s >= 0; s--) begin
            if (with_crc)
                put_crc_byte(x[8*s +: 8]);
            else
                put_byte(x[8*s +: 8]);
        end
    endtask

    // A raw byte of the zlib data, opening a new stored block when the last one is full.
    task automatic put_raw(input logic [7:0] b);
        logic [31:0] len;
        if (raw_left == 0)
            return;
        if (block_fill == 0) begin
            len = (raw_left > 65535) ? 32'd65535 : raw_left;
            put_crc_byte((raw_left <= 65535) ? 8'd1 : 8'd0);
            put_crc_byte(len[7:0]);
            put_crc_byte(len[15:8]);
            put_crc_byte(~len[7:0]);
            put_crc_byte(~len[15:8]);
        end
        put_crc_byte(b);
        adler_lo = (adler_lo + b) % 65521;
        adler_hi = (adler_hi + adler_lo) % 65521;
        raw_left--;
        block_fill++;
        if (block_fill >= 65535)
            block_fill = 0;
    endtask

    task automatic open_file();
        logic [7:0]  sig[8];
        logic [7:0]  ihdr[17];
        logic [31:0] c, raw, blocks;
        sig = '{8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10};
        frame_w = clamp_size(reg_width);
        frame_h = clamp_size(reg_height);
        raw = frame_h * (4 * frame_w + 1);
        blocks = (raw + 65534) / 65535;
        foreach (sig[i]) put_byte(sig[i]);
        ihdr = '{"I", "H", "D", "R", 8'd0, 8'd0, frame_w[15:8], frame_w[7:0],
                 8'd0, 8'd0, frame_h[15:8], frame_h[7:0], 8'd8, 8'd6, 8'd0, 8'd0, 8'd0};
        put_word(32'd13, 1'b0);
        c = 32'hFFFFFFFF;
        foreach (ihdr[i]) begin
            c = crc_update(c, ihdr[i]);
            put_byte(ihdr[i]);
        end
        put_word(~c, 1'b0);
        put_word(2 + raw + 5 * blocks + 4, 1'b0);
        idat_crc = 32'hFFFFFFFF;
        put_crc_byte("I");
        put_crc_byte("D");
        put_crc_byte("A");
        put_crc_byte("T");
        put_crc_byte(8'h78);
        put_crc_byte(8'h01);
        raw_left = raw;
        block_fill = 0;
        adler_lo = 1;
        adler_hi = 0;
        col_count = 0;
        row_count = 0;
        header_sent = 1;
    endtask

    task automatic close_file();
        logic [7:0]  iend[4];
        logic [31:0] c;
        iend = '{"I", "E", "N", "D"};
        put_word({adler_hi[15:0], adler_lo[15:0]}, 1'b1);
        put_word(~idat_crc, 1'b0);
        put_word(32'd0, 1'b0);
        c = 32'hFFFFFFFF;
        foreach (iend[i]) begin
            c = crc_update(c, iend[i]);
            put_byte(iend[i]);
        end
        put_word(~c, 1'b0);
        if (run_bytes.size() > 0)
            run_bytes[run_bytes.size()-1].end_of_file = 1'b1;
        header_sent = 0;
        trailer_owed = 0;
    endtask

    // Works out every byte that one accepted pixel causes and queues it.
    task automatic encode_pixel(input psde_pkg::t_pixel px);
        run_bytes.delete();
        if (trailer_owed) begin
            // The pixel after a one-pixel image only releases the held-back trailer.
            close_file();
        end else begin
            if (!header_sent)
                open_file();
            if (col_count == 0)
                put_raw(8'd0);
            put_raw(px.red);
            put_raw(px.green);
            put_raw(px.blue);
            put_raw(px.alpha);
            col_count++;
            if (col_count >= frame_w) begin
                col_count = 0;
                row_count++;
            end
            if (row_count >= frame_h) begin
                if (run_bytes.size() + 20 <= RUN_MAX)
                    close_file();
                else
                    trailer_owed = 1;
            end
        end
        if (run_bytes.size() > 0)
            run_bytes[run_bytes.size()-1].end_of_run = 1'b1;
        foreach (run_bytes[i]) expected_bytes.insert(expected_bytes.size(), run_bytes[i]);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        errors++;
    endtask

    // Clock with a 12 ns period.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // Receiver stall pattern: a randomly drawn mode picks free running, light stalling or
    // heavy stalling, so gaps land on every part of a pixel's bytes.
    logic [1:0] stall_mode;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_mode <= 2'd0;
        end else begin
            if (cycles % 64 == 0)
                stall_mode <= 2'($urandom_range(0, 2));
            case (stall_mode)
                2'd0: begin
                    i_out_stall <= 1'b0;
                end
                2'd1: begin
                    i_out_stall <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    i_out_stall <= ($urandom_range(0, 3) != 0);
                end
            endcase
        end
    end

    // Driver. Pixels go out in bursts with random gaps between them. A register write
    // waits until every predicted byte has come out and the drain counter has run down.
    bit sending_px, sending_cfg;
    int burst_left, gap_left, drain_left;
    always @(posedge i_clk) begin
        t_request head;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_pixel <= '0;
            i_cfg_valid <= 1'b0;
            i_cfg_index <= psde_pkg::CFG_WIDTH;
            i_cfg_data <= '0;
            sending_px = 0;
            sending_cfg = 0;
            burst_left = 1;
            gap_left = 0;
            drain_left = DRAIN_CYCLES;
            reg_width = 1;
            reg_height = 1;
            frame_w = 1;
            frame_h = 1;
            col_count = 0;
            row_count = 0;
            block_fill = 0;
            raw_left = 0;
            idat_crc = 32'hFFFFFFFF;
            adler_lo = 1;
            adler_hi = 0;
            header_sent = 0;
            trailer_owed = 0;
        end else begin
            if (sending_px && !o_in_stall) begin
                encode_pixel(pending[0].px);
                void'(pending.pop_front());
                sending_px = 0;
            end
            if (sending_cfg && o_cfg_ready) begin
                if (pending[0].idx == psde_pkg::CFG_WIDTH)
                    reg_width = pending[0].data;
                else
                    reg_height = pending[0].data;
                void'(pending.pop_front());
                sending_cfg = 0;
            end
            if (expected_bytes.size() != 0)
                drain_left = DRAIN_CYCLES;
            else if (drain_left > 0)
                drain_left--;
            if (!sending_px && !sending_cfg && pending.size() > 0) begin
                head = pending[0];
                if (head.is_cfg) begin
                    if (expected_bytes.size() == 0 && drain_left == 0) begin
                        sending_cfg = 1;
                        i_cfg_index <= head.idx;
                        i_cfg_data <= head.data;
                    end
                end else if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    sending_px = 1;
                    i_in_pixel <= head.px;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            i_in_valid <= sending_px;
            i_cfg_valid <= sending_cfg;
        end
    end

    // Monitor: every byte taken from the block is checked against the oldest prediction.
    always @(posedge i_clk) begin
        psde_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("unexpected byte", o_out_result.out_byte, -1);
            end else begin
                want = expected_bytes.pop_front();
                if (o_out_result.out_byte !== want.out_byte)
                    report_mismatch("out_byte", o_out_result.out_byte, want.out_byte);
                if (o_out_result.end_of_run !== want.end_of_run)
                    report_mismatch("end_of_run", o_out_result.end_of_run, want.end_of_run);
                if (o_out_result.end_of_file !== want.end_of_file)
                    report_mismatch("end_of_file", o_out_result.end_of_file, want.end_of_file);
            end
        end
    end

    function automatic psde_pkg::t_pixel random_pixel();
        return psde_pkg::t_pixel'($urandom);
    endfunction

    task automatic queue_cfg(input logic [1:0] idx, input logic [13:0] data);
        t_request r;
        r.is_cfg = 1;
        r.idx = idx;
        r.data = data;
        r.px = '0;
        pending.insert(pending.size(), r);
    endtask

    task automatic queue_px(input psde_pkg::t_pixel px);
        t_request r;
        r.is_cfg = 0;
        r.idx = psde_pkg::CFG_WIDTH;
        r.data = '0;
        r.px = px;
        pending.insert(pending.size(), r);
    endtask

    // Queues the pixels of one whole image; a one-pixel image needs one more pixel to
    // release its trailer. A size change in the middle may be asked for as well.
    task automatic queue_image(input int w, input int h, input bit mid_write);
        int n;
        n = w * h;
        if (n == 1)
            n = 2;
        for (int i = 0; i < n; i++) begin
            if (mid_write && i == n / 2)
                queue_cfg(($urandom_range(0, 1) == 0) ? psde_pkg::CFG_WIDTH
                                                      : psde_pkg::CFG_HEIGHT,
                          14'($urandom));
            queue_px(random_pixel());
        end
    endtask

    initial begin
        int w, h, total;
        i_rst_n = 1'b0;

        // Reset size: a single-pixel image, whose trailer comes with the next pixel.
        queue_px('0);
        queue_px('1);
        // Zero sizes act as 1 by 1.
        queue_cfg(psde_pkg::CFG_WIDTH, 14'd0);
        queue_cfg(psde_pkg::CFG_HEIGHT, 14'd0);
        queue_px(psde_pkg::t_pixel'(32'hFF00FF00));
        queue_px(psde_pkg::t_pixel'(32'h00FF00FF));
        // Small images with all-zero and all-one pixels.
        queue_cfg(psde_pkg::CFG_WIDTH, 14'd3);
        queue_cfg(psde_pkg::CFG_HEIGHT, 14'd2);
        for (int i = 0; i < 6; i++) queue_px((i % 2) ? '1 : '0);

        // Random small images, some with a register write while the file is open.
        total = 0;
        while (total < 210) begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 5);
            queue_cfg(psde_pkg::CFG_WIDTH, 14'(w));
            queue_cfg(psde_pkg::CFG_HEIGHT, 14'(h));
            queue_image(w, h, $urandom_range(0, 4) == 0);
            total += (w * h == 1) ? 2 : w * h;
        end

        // Oversized width, used as the maximum: the header and the first row start are checked.
        queue_cfg(psde_pkg::CFG_WIDTH, 14'h3FFF);
        queue_cfg(psde_pkg::CFG_HEIGHT, 14'd3);
        for (int i = 0; i < 6; i++) queue_px(random_pixel());

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        if (errors == 0 && expected_bytes.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/psde_pkg.sv
rtl/core/psde_ctrl.sv
rtl/core/psde_datapath.sv
rtl/core/png_stored_deflate_encoder.sv
tb/sv/tb_png_stored_deflate_encoder.sv
